// File: rtl/bpfix_pkg.sv
// ----------------------------------------------------------------------------
// bpfix_pkg
// Shared codes and types for the 3x3 defective pixel correction block.
// ----------------------------------------------------------------------------
package bpfix_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

    // Input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Reset values of the configuration registers
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd2048;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd1;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_SUM  = 6'b000100,
        S_TOT  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

endpackage

// File: rtl/bpfix_div.sv
// ----------------------------------------------------------------------------
// bpfix_div
// Restoring divider, one quotient bit per cycle, for the neighbor mean.
// ----------------------------------------------------------------------------
module bpfix_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    // Count the iterations and flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(NUM_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Shift the dividend out and the quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/bad_pixel_fix_3x3_unit.sv
// ----------------------------------------------------------------------------
// bad_pixel_fix_3x3_unit
// Streaming defective pixel correction: a bad pixel becomes the floor of the
// mean of the good pixels in its edge-clipped 3x3 neighborhood.
// ----------------------------------------------------------------------------
// Latency: a result leaves W+1 pixels after its own pixel. An accepted item passes S_LOAD
// (twice for the first flush of a single-row frame); a pixel without result then
// returns to S_IDLE, a result goes on through S_SUM, S_TOT for a bad pixel, the
// bit-serial divider S_DIV if it has a good neighbor, and S_OUT. An ignored flush
// is not loaded, and input is ready only in S_IDLE. One item in work at a time.
// Reset (synchronous, active low) clears raster position and pending count.
module bad_pixel_fix_3x3_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [15:0] i_pixel_value,
    input  logic        i_is_bad,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_fixed_value,
    output logic        o_was_replaced,
    output logic        o_frame_last
);
    import bpfix_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int PW  = $clog2(MAX_WIDTH + 2);
    localparam int CW  = PIXEL_BITS + 1;
    localparam int SW  = PIXEL_BITS + 4;
    localparam int RSW = PIXEL_BITS + 2;

    // Configuration and raster position
    logic [11:0]   r_fw;
    logic [15:0]   r_fh;
    logic [AW-1:0] r_col;
    logic [15:0]   r_row;
    logic [PW-1:0] r_pend;
    logic [AW-1:0] r_ec;
    logic [15:0]   r_er;

    logic [WW-1:0] w;
    logic [15:0]   h;

    // Item context
    t_state        r_state;
    logic          r_is_pix;
    logic          r_extra;
    logic          r_emit;
    logic [CW-1:0] r_bottom;
    logic [CW-1:0] r_pix;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_addr2;
    logic          r_clip_t;
    logic          r_clip_b;
    logic          r_clip_l;
    logic          r_clip_r;
    logic          r_last;

    // Line memory: {two rows above, one row above}
    logic [2*CW-1:0] r_mem [MAX_WIDTH];
    logic [2*CW-1:0] r_rd;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    logic [CW-1:0]   r_win [9];
    logic [RSW-1:0]  r_rsum [3];
    logic [1:0]      r_rcnt [3];

    logic [PIXEL_BITS-1:0] r_res;
    logic                  r_res_repl;

    logic          r_out_valid;
    logic [15:0]   r_out_fixed;
    logic          r_out_repl;
    logic          r_out_last;

    // Accept-time decode
    logic          accept;
    logic          frame_start;
    logic          flush_ok;
    logic          emit_pix;
    logic          emit_now;
    logic [AW-1:0] pos_c;
    logic [15:0]   pos_r;
    logic [PW-1:0] pend_base;
    logic [AW-1:0] next_ec;
    logic          ec_wrap;
    logic          col_wrap;
    logic [CW-1:0] pix_in;

    logic [SW-1:0] tot_sum;
    logic [3:0]    tot_cnt;
    logic          div_start;
    logic          div_done;
    logic [SW-1:0] div_quo;

    // Effective frame size
    always_comb begin
        if (r_fw == '0) begin
            w = WW'(1);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_fw);
        end
        h = (r_fh == '0) ? 16'd1 : r_fh;
    end

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign pix_in  = {i_is_bad, PIXEL_BITS'(32'(i_pixel_value))};

    // Decode position and emission of the incoming item
    always_comb begin
        frame_start = (r_row == '0) && (r_col == '0);
        flush_ok    = frame_start && (r_pend != '0);
        emit_pix    = (r_row >= 16'd2) || ((r_row == 16'd1) && (r_col != '0));
        pos_c       = (frame_start && (i_kind == KIND_PIXEL)) ? '0 : r_ec;
        pos_r       = (frame_start && (i_kind == KIND_PIXEL)) ? '0 : r_er;
        pend_base   = (frame_start && (i_kind == KIND_PIXEL)) ? '0 : r_pend;
        emit_now    = (i_kind == KIND_PIXEL) ? emit_pix : flush_ok;
        ec_wrap     = (WW'(pos_c) + WW'(1)) == w;
        next_ec     = ec_wrap ? '0 : AW'(pos_c + AW'(1));
        col_wrap    = (WW'(r_col) + WW'(1)) == w;
    end

    // Sequence one item through read, shift, sum, divide and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && ((i_kind == KIND_PIXEL) || flush_ok)) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_extra) begin
                        r_state <= S_LOAD;
                    end else if (r_emit) begin
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SUM: begin
                    r_state <= r_win[4][CW-1] ? S_TOT : S_OUT;
                end
                S_TOT: begin
                    r_state <= (tot_cnt == '0) ? S_OUT : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Raster position, pending count and next result position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= FRAME_WIDTH_RST;
            r_fh   <= FRAME_HEIGHT_RST;
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
            r_ec   <= '0;
            r_er   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT) begin
                r_col  <= '0;
                r_row  <= '0;
                r_pend <= '0;
                r_ec   <= '0;
                r_er   <= '0;
            end
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                r_fw <= i_cfg_data[11:0];
            end
            if (i_cfg_index == REG_FRAME_HEIGHT) begin
                r_fh <= i_cfg_data;
            end
        end else if (accept && ((i_kind == KIND_PIXEL) || flush_ok)) begin
            if (i_kind == KIND_PIXEL) begin
                r_pend <= emit_now ? pend_base : PW'(pend_base + PW'(1));
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= (16'(r_row + 16'd1) == h) ? '0 : 16'(r_row + 16'd1);
                end else begin
                    r_col <= AW'(r_col + AW'(1));
                end
            end else begin
                r_pend <= PW'(r_pend - PW'(1));
            end
            if (emit_now) begin
                r_ec <= next_ec;
                if (ec_wrap) begin
                    r_er <= (16'(pos_r + 16'd1) == h) ? '0 : 16'(pos_r + 16'd1);
                end else begin
                    r_er <= pos_r;
                end
            end else begin
                r_ec <= pos_c;
                r_er <= pos_r;
            end
        end
    end

    // Latch the item context at acceptance
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_pix <= (i_kind == KIND_PIXEL);
            r_emit   <= emit_now;
            r_pix    <= pix_in;
            r_bottom <= (i_kind == KIND_PIXEL) ? pix_in : {1'b1, PIXEL_BITS'(0)};
            r_addr   <= r_col;
            r_addr2  <= next_ec;
            r_clip_t <= (pos_r == '0);
            r_clip_b <= (pos_r == 16'(h - 16'd1));
            r_clip_l <= (pos_c == '0);
            r_clip_r <= ec_wrap;
            r_last   <= (i_kind == KIND_FLUSH) && (pos_r == 16'(h - 16'd1)) && ec_wrap;
        end
    end

    // Single-row frame: the first flush shifts twice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra <= 1'b0;
        end else if (accept) begin
            r_extra <= (i_kind == KIND_FLUSH) && (h == 16'd1) &&
                       (r_er == '0) && (r_ec == '0);
        end else if (r_state == S_LOAD) begin
            r_extra <= 1'b0;
        end
    end

    // Line memory read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr2;
        if (accept) begin
            rd_en = 1'b1;
            if (i_kind == KIND_PIXEL) begin
                rd_addr = r_col;
            end else if ((h == 16'd1) && (r_er == '0) && (r_ec == '0)) begin
                rd_addr = '0;
            end else begin
                rd_addr = next_ec;
            end
        end else if ((r_state == S_LOAD) && r_extra) begin
            rd_en   = 1'b1;
            rd_addr = r_addr2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Write back the column: age one row, store the new pixel
    always_ff @(posedge i_clk) begin
        if ((r_state == S_LOAD) && r_is_pix) begin
            r_mem[r_addr] <= {r_rd[CW-1:0], r_pix};
        end
    end

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]     <= r_win[i*3+1];
                r_win[i*3+1]   <= r_win[i*3+2];
            end
            r_win[2] <= r_rd[2*CW-1:CW];
            r_win[5] <= r_rd[CW-1:0];
            r_win[8] <= r_bottom;
        end
    end

    // Row partial sums over the good, unclipped neighbors
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            for (int i = 0; i < 3; i++) begin
                logic [RSW-1:0] s;
                logic [1:0]     n;
                logic           row_ok;
                logic           take;
                s      = '0;
                n      = '0;
                row_ok = !((i == 0) && r_clip_t) && !((i == 2) && r_clip_b);
                for (int j = 0; j < 3; j++) begin
                    take = row_ok && !((j == 0) && r_clip_l) && !((j == 2) && r_clip_r) &&
                           !r_win[i*3+j][CW-1];
                    if (take) begin
                        s = RSW'(s + RSW'(r_win[i*3+j][PIXEL_BITS-1:0]));
                        n = 2'(n + 2'd1);
                    end
                end
                r_rsum[i] <= s;
                r_rcnt[i] <= n;
            end
        end
    end

    assign tot_sum   = SW'(r_rsum[0]) + SW'(r_rsum[1]) + SW'(r_rsum[2]);
    assign tot_cnt   = 4'(r_rcnt[0]) + 4'(r_rcnt[1]) + 4'(r_rcnt[2]);
    assign div_start = (r_state == S_TOT) && (tot_cnt != '0);

    bpfix_div #(
        .NUM_W (SW),
        .DEN_W (4)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (tot_sum),
        .i_den   (tot_cnt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Capture the result value
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SUM) && !r_win[4][CW-1]) begin
            r_res      <= r_win[4][PIXEL_BITS-1:0];
            r_res_repl <= 1'b0;
        end else if ((r_state == S_TOT) && (tot_cnt == '0)) begin
            r_res      <= '0;
            r_res_repl <= 1'b1;
        end else if ((r_state == S_DIV) && div_done) begin
            r_res      <= div_quo[PIXEL_BITS-1:0];
            r_res_repl <= 1'b1;
        end
    end

    // Output register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_out_valid || i_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || i_ready)) begin
            r_out_fixed <= 16'(32'(r_res));
            r_out_repl  <= r_res_repl;
            r_out_last  <= r_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_fixed_value  = r_out_fixed;
    assign o_was_replaced = r_out_repl;
    assign o_frame_last   = r_out_last;

endmodule
